// File: rtl/msp_pkg.sv
package msp_pkg;

    // Channels that carry storage and an output pin.
    localparam int MAX_CH        = 32;
    localparam int IDX_W         = 5;
    localparam int CHANNELS_DEF  = 32;

    // Stream payload widths.
    localparam int IN_DATA_W     = 24;
    localparam int IN_USER_W     = 3;
    localparam int CHAN_W        = 7;
    localparam int VALUE_W       = 12;
    localparam int OUT_DATA_W    = 40;
    localparam int PINS_W        = 32;
    localparam int RD_W          = 8;

    // Configuration port.
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP  = 1'b1;

    localparam logic [7:0]  LEAD_RESET = 8'd62;
    localparam logic [15:0] GAP_RESET  = 16'd2500;

    // Frame and position constants.
    localparam logic [15:0] DOWN_SLOTS    = 16'd251;
    localparam logic [7:0]  POS_RESET     = 8'd255;
    localparam logic [7:0]  MIN_RESET     = 8'd64;
    localparam logic [7:0]  MAX_RESET     = 8'd192;
    localparam logic [VALUE_W-1:0] DEG_MAX = 12'd180;
    localparam logic [VALUE_W-1:0] US_LO   = 12'd500;
    localparam logic [VALUE_W-1:0] US_MID  = 12'd1500;
    localparam logic [VALUE_W-1:0] US_HI   = 12'd2500;

    // floor(p / 180) = ((p >> 2) * RECIP_45) >> RECIP_SHIFT for p below 2**16.
    localparam logic [14:0] RECIP_45    = 15'd23302;
    localparam int          RECIP_SHIFT = 20;
    localparam int          QUOT_W      = 29;

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    // Function codes on the input stream.
    localparam logic [IN_USER_W-1:0] FN_TICK   = 3'd0;
    localparam logic [IN_USER_W-1:0] FN_ATTACH = 3'd1;
    localparam logic [IN_USER_W-1:0] FN_DETACH = 3'd2;
    localparam logic [IN_USER_W-1:0] FN_WRITE  = 3'd3;
    localparam logic [IN_USER_W-1:0] FN_SETMIN = 3'd4;
    localparam logic [IN_USER_W-1:0] FN_SETMAX = 3'd5;
    localparam logic [IN_USER_W-1:0] FN_READ   = 3'd6;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_ATTACH = 3'd1,
        OP_DETACH = 3'd2,
        OP_WRITE  = 3'd3,
        OP_SETMIN = 3'd4,
        OP_SETMAX = 3'd5,
        OP_READ   = 3'd6,
        OP_NOP    = 3'd7
    } op_t;

    // A classified request: arg holds clamped degrees or a finished slot value.
    typedef struct packed {
        op_t             op;
        logic [IDX_W-1:0] idx;
        logic [7:0]      arg;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_RUN = 3'b001,
        ST_MUL = 3'b010,
        ST_DIV = 3'b100
    } back_state_t;

    typedef enum logic [2:0] {
        PH_LEAD = 3'b001,
        PH_DOWN = 3'b010,
        PH_GAP  = 3'b100
    } phase_t;

endpackage

// File: rtl/msp_front.sv
module msp_front #(
    parameter int CHANNELS = msp_pkg::CHANNELS_DEF
) (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [msp_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic [msp_pkg::IN_USER_W-1:0] s_tuser,
    input  logic                          q_full,
    output logic                          q_push,
    output msp_pkg::cmd_t                 q_cmd
);

    localparam int LIVE = (CHANNELS > msp_pkg::MAX_CH) ? msp_pkg::MAX_CH : CHANNELS;

    logic [msp_pkg::CHAN_W-1:0]  chan;
    logic [msp_pkg::VALUE_W-1:0] val;
    logic [msp_pkg::VALUE_W-1:0] us_min;
    logic [msp_pkg::VALUE_W-1:0] us_max;
    logic [msp_pkg::VALUE_W-1:0] off_min;
    logic [msp_pkg::VALUE_W-1:0] off_max;
    logic                        chan_ok;

    assign chan    = s_tdata[msp_pkg::CHAN_W-1:0];
    assign val     = s_tdata[msp_pkg::CHAN_W +: msp_pkg::VALUE_W];
    assign chan_ok = (32'(chan) < LIVE);

    always_comb
    begin
        us_min = (val < msp_pkg::US_LO) ? msp_pkg::US_LO :
                 ((val > msp_pkg::US_MID) ? msp_pkg::US_MID : val);
        us_max = (val < msp_pkg::US_MID) ? msp_pkg::US_MID :
                 ((val > msp_pkg::US_HI) ? msp_pkg::US_HI : val);
        off_min = us_min - msp_pkg::US_LO;
        off_max = us_max - msp_pkg::US_LO;

        q_cmd.idx = chan[msp_pkg::IDX_W-1:0];
        q_cmd.arg = '0;
        q_cmd.op  = msp_pkg::OP_NOP;
        unique case (s_tuser)
            msp_pkg::FN_TICK:   q_cmd.op = msp_pkg::OP_TICK;
            msp_pkg::FN_ATTACH: q_cmd.op = msp_pkg::OP_ATTACH;
            msp_pkg::FN_DETACH: q_cmd.op = msp_pkg::OP_DETACH;
            msp_pkg::FN_WRITE:
            begin
                q_cmd.op  = msp_pkg::OP_WRITE;
                q_cmd.arg = (val > msp_pkg::DEG_MAX) ? msp_pkg::DEG_MAX[7:0] : val[7:0];
            end
            msp_pkg::FN_SETMIN:
            begin
                q_cmd.op  = msp_pkg::OP_SETMIN;
                q_cmd.arg = off_min[10:3];
            end
            msp_pkg::FN_SETMAX:
            begin
                q_cmd.op  = msp_pkg::OP_SETMAX;
                q_cmd.arg = off_max[10:3];
            end
            msp_pkg::FN_READ:   q_cmd.op = msp_pkg::OP_READ;
            default:            q_cmd.op = msp_pkg::OP_NOP;
        endcase
        // Commands other than a tick to a channel without storage still give a result but change nothing.
        if (!chan_ok && (q_cmd.op != msp_pkg::OP_TICK))
        begin
            q_cmd.op = msp_pkg::OP_NOP;
        end
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

endmodule

// File: rtl/msp_queue.sv
module msp_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  msp_pkg::cmd_t push_cmd,
    input  logic          pop,
    output msp_pkg::cmd_t head,
    output logic          empty,
    output logic          full
);

    localparam logic [msp_pkg::QPTR_W:0] DEPTH = (msp_pkg::QPTR_W + 1)'(msp_pkg::QUEUE_DEPTH);

    msp_pkg::cmd_t               slots_reg [msp_pkg::QUEUE_DEPTH];
    logic [msp_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [msp_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [msp_pkg::QPTR_W:0]    count_reg;
    logic [msp_pkg::QPTR_W:0]    count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == DEPTH);
    assign head  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/msp_back.sv
module msp_back #(
    parameter int CHANNELS = msp_pkg::CHANNELS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [msp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [msp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  msp_pkg::cmd_t                  head,
    input  logic                           q_empty,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [msp_pkg::OUT_DATA_W-1:0] m_tdata
);

    localparam int LIVE = (CHANNELS > msp_pkg::MAX_CH) ? msp_pkg::MAX_CH : CHANNELS;

    logic [7:0]                lead_reg;
    logic [15:0]               gap_reg;

    msp_pkg::back_state_t      state_reg, state_next;
    msp_pkg::phase_t           phase_reg, phase_next;
    logic [15:0]               cnt_reg, cnt_next;
    logic [msp_pkg::PINS_W-1:0] pins_reg, pins_next;
    logic [msp_pkg::PINS_W-1:0] active_reg, active_next;
    logic                      pending_reg, pending_next;
    logic [7:0]                pos_reg     [msp_pkg::MAX_CH];
    logic [7:0]                pos_next    [msp_pkg::MAX_CH];
    logic [7:0]                applied_reg [msp_pkg::MAX_CH];
    logic [7:0]                applied_next[msp_pkg::MAX_CH];
    logic [7:0]                min_reg     [msp_pkg::MAX_CH];
    logic [7:0]                min_next    [msp_pkg::MAX_CH];
    logic [7:0]                max_reg     [msp_pkg::MAX_CH];
    logic [7:0]                max_next    [msp_pkg::MAX_CH];

    // Write datapath: product, scaled quotient and the channel's minimum.
    logic [15:0]               prod_reg, prod_next;
    logic [msp_pkg::QUOT_W-1:0] quot_reg, quot_next;
    logic [7:0]                lo_reg, lo_next;
    logic [msp_pkg::IDX_W-1:0] widx_reg, widx_next;

    logic                      out_valid_reg, out_valid_next;
    logic [msp_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic                      out_free;
    logic                      out_load;
    logic [7:0]                rd;
    logic [7:0]                lo;
    logic [7:0]                hi;
    logic [7:0]                range_w;
    logic [9:0]                pos_sum;
    logic [15:0]               cnt_inc;

    assign out_free = !out_valid_reg || m_tready;
    assign q_pop    = (state_reg == msp_pkg::ST_RUN) && !q_empty && out_free;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        pins_next    = pins_reg;
        active_next  = active_reg;
        pending_next = pending_reg;
        pos_next     = pos_reg;
        applied_next = applied_reg;
        min_next     = min_reg;
        max_next     = max_reg;
        prod_next    = prod_reg;
        quot_next    = quot_reg;
        lo_next      = lo_reg;
        widx_next    = widx_reg;
        out_load     = 1'b0;
        rd           = '0;
        lo           = min_reg[head.idx];
        hi           = max_reg[head.idx];
        range_w      = (hi >= lo) ? (hi - lo) : 8'd0;
        pos_sum      = 10'(quot_reg[msp_pkg::QUOT_W-1:msp_pkg::RECIP_SHIFT]) + 10'(lo_reg);
        cnt_inc      = cnt_reg + 16'd1;

        unique case (state_reg)
            msp_pkg::ST_RUN:
            begin
                if (q_pop)
                begin
                    out_load = 1'b1;
                    case (head.op)
                        msp_pkg::OP_TICK:
                        begin
                            unique case (phase_reg)
                                msp_pkg::PH_DOWN:
                                begin
                                    for (int i = 0; i < LIVE; i++)
                                    begin
                                        if ((cnt_reg[15:8] == 8'd0) &&
                                            (applied_reg[i] == cnt_reg[7:0]))
                                        begin
                                            pins_next[i] = 1'b0;
                                        end
                                    end
                                    cnt_next = cnt_inc;
                                    if (cnt_inc >= msp_pkg::DOWN_SLOTS)
                                    begin
                                        phase_next = msp_pkg::PH_GAP;
                                        cnt_next   = '0;
                                        // New positions take effect only between frames.
                                        if (pending_reg)
                                        begin
                                            applied_next = pos_reg;
                                            pending_next = 1'b0;
                                        end
                                    end
                                end
                                msp_pkg::PH_GAP:
                                begin
                                    cnt_next = cnt_inc;
                                    if ((cnt_inc == '0) || (cnt_inc >= gap_reg))
                                    begin
                                        phase_next = msp_pkg::PH_LEAD;
                                        cnt_next   = '0;
                                    end
                                end
                                default:
                                begin
                                    if (cnt_reg == '0)
                                    begin
                                        pins_next = pins_reg | active_reg;
                                    end
                                    cnt_next = cnt_inc;
                                    if ((cnt_inc == '0) || (cnt_inc >= 16'(lead_reg)))
                                    begin
                                        phase_next = msp_pkg::PH_DOWN;
                                        cnt_next   = '0;
                                    end
                                end
                            endcase
                        end
                        msp_pkg::OP_ATTACH:
                        begin
                            active_next[head.idx] = 1'b1;
                        end
                        msp_pkg::OP_DETACH:
                        begin
                            active_next[head.idx] = 1'b0;
                            pins_next[head.idx]   = 1'b0;
                        end
                        msp_pkg::OP_WRITE:
                        begin
                            // The result is delivered once the position is stored.
                            out_load   = 1'b0;
                            prod_next  = 16'(head.arg) * 16'(range_w);
                            lo_next    = lo;
                            widx_next  = head.idx;
                            state_next = msp_pkg::ST_MUL;
                        end
                        msp_pkg::OP_SETMIN:
                        begin
                            min_next[head.idx] = head.arg;
                        end
                        msp_pkg::OP_SETMAX:
                        begin
                            max_next[head.idx] = head.arg;
                        end
                        msp_pkg::OP_READ:
                        begin
                            rd = pos_reg[head.idx];
                        end
                        default:
                        begin
                            rd = '0;
                        end
                    endcase
                end
            end
            msp_pkg::ST_MUL:
            begin
                quot_next  = msp_pkg::QUOT_W'(prod_reg[15:2]) *
                             msp_pkg::QUOT_W'(msp_pkg::RECIP_45);
                state_next = msp_pkg::ST_DIV;
            end
            msp_pkg::ST_DIV:
            begin
                pos_next[widx_reg] = (pos_sum > 10'd255) ? 8'd255 : pos_sum[7:0];
                pending_next       = 1'b1;
                out_load           = 1'b1;
                state_next         = msp_pkg::ST_RUN;
            end
            default:
            begin
                state_next = msp_pkg::ST_RUN;
            end
        endcase

        out_valid_next = out_load ? 1'b1 : (out_valid_reg && !m_tready);
        out_data_next  = out_load ? {rd, pins_next} : out_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg      <= msp_pkg::LEAD_RESET;
            gap_reg       <= msp_pkg::GAP_RESET;
            state_reg     <= msp_pkg::ST_RUN;
            phase_reg     <= msp_pkg::PH_LEAD;
            cnt_reg       <= '0;
            pins_reg      <= '0;
            active_reg    <= '0;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < msp_pkg::MAX_CH; i++)
            begin
                pos_reg[i]     <= msp_pkg::POS_RESET;
                applied_reg[i] <= msp_pkg::POS_RESET;
                min_reg[i]     <= msp_pkg::MIN_RESET;
                max_reg[i]     <= msp_pkg::MAX_RESET;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    msp_pkg::CFG_LEAD: lead_reg <= cfg_data[7:0];
                    msp_pkg::CFG_GAP:  gap_reg  <= cfg_data;
                    default:           lead_reg <= lead_reg;
                endcase
            end
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            pins_reg      <= pins_next;
            active_reg    <= active_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            applied_reg   <= applied_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        quot_reg     <= quot_next;
        lo_reg       <= lo_next;
        widx_reg     <= widx_next;
        out_data_reg <= out_data_next;
    end

    // An output may only be high while its channel is attached.
    a_pins_active: assert property (@(posedge clk) disable iff (!rst_n)
        (pins_reg & ~active_reg) == '0)
        else $error("servo output high on a detached channel");

    // The write result is produced into an empty output register.
    a_div_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == msp_pkg::ST_DIV) |-> !out_valid_reg)
        else $error("write result would overwrite a pending result");

    // The down window counter never reaches the window length.
    a_down_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == msp_pkg::PH_DOWN) |-> (cnt_reg < msp_pkg::DOWN_SLOTS))
        else $error("down window counter out of range");

    // Leaving the down window applies any pending positions.
    a_apply_at_gap: assert property (@(posedge clk) disable iff (!rst_n)
        ((phase_reg == msp_pkg::PH_DOWN) && (phase_next == msp_pkg::PH_GAP))
        |=> !pending_reg)
        else $error("pending positions not applied at end of down window");

    // No request leaves the queue while a write is in flight.
    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != msp_pkg::ST_RUN) |-> !q_pop)
        else $error("request taken while a write is in progress");

endmodule

// File: rtl/multichannel_servo_pulse_generator.sv
// Requests pass through the queue and the output register; a write also passes through the
// product and quotient registers. The back end takes one request per cycle while the output
// is free; a write holds it while its degree-to-slot scaling passes two multiplier steps.
// A two-entry queue lets requests be accepted while the back end or the output stalls.
// Reset (rst_n, asynchronous, active low) restores all positions, limits, the frame and
// both window lengths at once; no clearing pass is needed.
module multichannel_servo_pulse_generator #(
    parameter int CHANNELS = msp_pkg::CHANNELS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [msp_pkg::IN_DATA_W-1:0]  s_tdata,   // channel[6:0], value[18:7], zero pad
    input  logic [msp_pkg::IN_USER_W-1:0]  s_tuser,   // func[2:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [msp_pkg::OUT_DATA_W-1:0] m_tdata,   // servo_pins[31:0], read_value[39:32]
    input  logic                           cfg_we,
    input  logic [msp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [msp_pkg::CFG_DATA_W-1:0] cfg_data
);

    msp_pkg::cmd_t push_cmd;
    msp_pkg::cmd_t head;
    logic          push;
    logic          pop;
    logic          q_empty;
    logic          q_full;

    msp_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (push),
        .q_cmd    (push_cmd)
    );

    msp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    msp_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .head      (head),
        .q_empty   (q_empty),
        .q_pop     (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// File: tb/multichannel_servo_pulse_generator_test.sv
module multichannel_servo_pulse_generator_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASES = 5;

    typedef struct packed {
        logic [31:0] pins;
        logic [7:0]  rd;
    } servo_result_t;

    typedef struct packed {
        msp_pkg::op_t op;
        logic [6:0]   ch;
        logic [11:0]  val;
        logic         typed;
        logic [31:0]  pins;
        logic [7:0]   rd;
    } opening_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [msp_pkg::IN_DATA_W-1:0] s_tdata = '0;    // channel[6:0], value[18:7], zero pad
    logic [msp_pkg::IN_USER_W-1:0] s_tuser = '0;    // func[2:0]
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [msp_pkg::OUT_DATA_W-1:0] m_tdata;        // servo_pins[31:0], read_value[39:32]
    logic cfg_we = 1'b0;
    logic [msp_pkg::CFG_IDX_W-1:0] cfg_index = msp_pkg::CFG_LEAD;
    logic [msp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Predicted block state.
    logic [7:0]  lead_len;
    logic [15:0] gap_len;
    logic [31:0] active_bits;
    logic [31:0] pin_state;
    logic [7:0]  pos_written [32];
    logic [7:0]  pos_applied [32];
    logic [7:0]  min_limit [32];
    logic [7:0]  max_limit [32];
    msp_pkg::phase_t frame_phase;
    logic [15:0] slot;
    logic        reorder;

    servo_result_t pending_results[$];
    int accepted_count = 0;
    int result_count = 0;
    int read_count = 0;
    int error_count = 0;
    bit hold_output = 1'b0;
    bit steady = 1'b0;

    multichannel_servo_pulse_generator uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void servo_reset_state();
        lead_len = msp_pkg::LEAD_RESET;
        gap_len = msp_pkg::GAP_RESET;
        active_bits = '0;
        pin_state = '0;
        for (int i = 0; i < 32; i++)
        begin
            pos_written[i] = 8'd255;
            pos_applied[i] = 8'd255;
            min_limit[i] = 8'd64;
            max_limit[i] = 8'd192;
        end
        frame_phase = msp_pkg::PH_LEAD;
        slot = '0;
        reorder = 1'b0;
    endfunction

    function automatic void advance_slot();
        case (frame_phase)
            msp_pkg::PH_DOWN:
            begin
                if (slot < 16'd251)
                    for (int i = 0; i < 32; i++)
                        if ({8'd0, pos_applied[i]} == slot)
                            pin_state[i] = 1'b0;
                slot = slot + 16'd1;
                if (slot >= 16'd251)
                begin
                    frame_phase = msp_pkg::PH_GAP;
                    slot = '0;
                    if (reorder)
                    begin
                        pos_applied = pos_written;
                        reorder = 1'b0;
                    end
                end
            end
            msp_pkg::PH_GAP:
            begin
                slot = slot + 16'd1;
                if (slot == 16'd0 || slot >= gap_len)
                begin
                    frame_phase = msp_pkg::PH_LEAD;
                    slot = '0;
                end
            end
            default:
            begin
                if (slot == 16'd0)
                    pin_state = pin_state | active_bits;
                slot = slot + 16'd1;
                if (slot == 16'd0 || slot >= {8'd0, lead_len})
                begin
                    frame_phase = msp_pkg::PH_DOWN;
                    slot = '0;
                end
            end
        endcase
    endfunction

    function automatic servo_result_t predict_servo(msp_pkg::op_t op, logic [6:0] ch,
                                                    logic [11:0] val);
        servo_result_t res;
        int unsigned lo, hi, span, deg, pos, us;
        logic [4:0] idx;
        res.rd = '0;
        idx = ch[4:0];
        if (op == msp_pkg::OP_TICK)
            advance_slot();
        else if (ch < 7'd32)
        begin
            case (op)
                msp_pkg::OP_ATTACH: active_bits[idx] = 1'b1;
                msp_pkg::OP_DETACH:
                begin
                    active_bits[idx] = 1'b0;
                    pin_state[idx] = 1'b0;
                end
                msp_pkg::OP_WRITE:
                begin
                    lo = 32'(min_limit[idx]);
                    hi = 32'(max_limit[idx]);
                    span = (hi >= lo) ? hi - lo : 0;
                    deg = (val > 12'd180) ? 180 : 32'(val);
                    pos = deg * span / 180 + lo;
                    pos_written[idx] = (pos > 255) ? 8'd255 : pos[7:0];
                    reorder = 1'b1;
                end
                msp_pkg::OP_SETMIN:
                begin
                    us = (val < 12'd500) ? 500 : ((val > 12'd1500) ? 1500 : 32'(val));
                    min_limit[idx] = 8'((us - 500) >> 3);
                end
                msp_pkg::OP_SETMAX:
                begin
                    us = (val < 12'd1500) ? 1500 : ((val > 12'd2500) ? 2500 : 32'(val));
                    max_limit[idx] = 8'((us - 500) >> 3);
                end
                msp_pkg::OP_READ: res.rd = pos_written[idx];
                default: ;
            endcase
        end
        res.pins = pin_state;
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 70)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Offers one request and records its expected result once it is taken.
    task automatic send_request(msp_pkg::op_t op, logic [6:0] ch, logic [11:0] val,
                                logic typed, logic [31:0] pins, logic [7:0] rd);
        int gap;
        servo_result_t res;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {5'd0, val, ch};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        res = predict_servo(op, ch, val);
        if (typed)
        begin
            res.pins = pins;
            res.rd = rd;
        end
        pending_results.push_back(res);
        accepted_count++;
        if (op == msp_pkg::OP_READ)
            read_count++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic program_windows(logic [7:0] lead, logic [15:0] gap);
        wait_drained();
        repeat (8) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= msp_pkg::CFG_LEAD;
        cfg_data <= {8'd0, lead};
        @(posedge clk);
        cfg_index <= msp_pkg::CFG_GAP;
        cfg_data <= gap;
        @(posedge clk);
        cfg_we <= 1'b0;
        lead_len = lead;
        gap_len = gap;
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        servo_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            result_count++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: servo_pins %h, read_value %h",
                       m_tdata[31:0], m_tdata[39:32]);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[31:0] !== want.pins)
                begin
                    $error("servo_pins: expected %h, got %h", want.pins, m_tdata[31:0]);
                    error_count++;
                end
                if (m_tdata[39:32] !== want.rd)
                begin
                    $error("read_value: expected %h, got %h", want.rd, m_tdata[39:32]);
                    error_count++;
                end
            end
        end
    end

    // Receiver: random stalls, with one long hold-off when asked for.
    initial
    begin
        int run_len, stall;
        forever
        begin
            if (hold_output)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_output = 1'b0;
            end
            run_len = steady ? $urandom_range(20, 60) : $urandom_range(1, 12);
            m_tready <= 1'b1;
            repeat (run_len) @(posedge clk);
            stall = pick_gap();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    initial
    begin
        #1_500_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        opening_row_t opening_requests[25];
        logic [7:0]  lead_set [PHASES];
        logic [15:0] gap_set [PHASES];
        int          phase_items [PHASES];
        int          start_count, r;
        bit          paused;
        bit          held;
        msp_pkg::op_t op;
        logic [6:0]  ch;
        logic [11:0] val;

        // Nothing attached after reset, so pins stay low until a tick in the lead window.
        opening_requests = '{
            '{msp_pkg::OP_READ,   7'd0,   12'd0,    1'b1, 32'h0,        8'd255},
            '{msp_pkg::OP_READ,   7'd127, 12'd4095, 1'b1, 32'h0,        8'd0},
            '{msp_pkg::OP_NOP,    7'd31,  12'd4095, 1'b1, 32'h0,        8'd0},
            '{msp_pkg::OP_ATTACH, 7'd0,   12'd0,    1'b1, 32'h0,        8'd0},
            '{msp_pkg::OP_ATTACH, 7'd31,  12'd0,    1'b1, 32'h0,        8'd0},
            '{msp_pkg::OP_TICK,   7'd0,   12'd0,    1'b1, 32'h80000001, 8'd0},
            '{msp_pkg::OP_ATTACH, 7'd127, 12'd0,    1'b1, 32'h80000001, 8'd0},
            '{msp_pkg::OP_SETMIN, 7'd0,   12'd0,    1'b1, 32'h80000001, 8'd0},
            '{msp_pkg::OP_SETMAX, 7'd0,   12'd4095, 1'b1, 32'h80000001, 8'd0},
            '{msp_pkg::OP_WRITE,  7'd0,   12'd4095, 1'b1, 32'h80000001, 8'd0},
            '{msp_pkg::OP_READ,   7'd0,   12'd0,    1'b1, 32'h80000001, 8'd250},
            '{msp_pkg::OP_SETMIN, 7'd31,  12'd4095, 1'b1, 32'h80000001, 8'd0},
            '{msp_pkg::OP_SETMAX, 7'd31,  12'd0,    1'b1, 32'h80000001, 8'd0},
            '{msp_pkg::OP_WRITE,  7'd31,  12'd90,   1'b1, 32'h80000001, 8'd0},
            '{msp_pkg::OP_READ,   7'd31,  12'd0,    1'b1, 32'h80000001, 8'd125},
            '{msp_pkg::OP_WRITE,  7'd1,   12'd0,    1'b1, 32'h80000001, 8'd0},
            '{msp_pkg::OP_READ,   7'd1,   12'd0,    1'b1, 32'h80000001, 8'd64},
            '{msp_pkg::OP_WRITE,  7'd2,   12'd180,  1'b1, 32'h80000001, 8'd0},
            '{msp_pkg::OP_READ,   7'd2,   12'd0,    1'b1, 32'h80000001, 8'd192},
            '{msp_pkg::OP_DETACH, 7'd31,  12'd0,    1'b1, 32'h00000001, 8'd0},
            '{msp_pkg::OP_DETACH, 7'd32,  12'd0,    1'b1, 32'h00000001, 8'd0},
            '{msp_pkg::OP_READ,   7'd32,  12'd0,    1'b1, 32'h00000001, 8'd0},
            '{msp_pkg::OP_WRITE,  7'd3,   12'd181,  1'b0, 32'h0,        8'd0},
            '{msp_pkg::OP_ATTACH, 7'd5,   12'd0,    1'b0, 32'h0,        8'd0},
            '{msp_pkg::OP_TICK,   7'd0,   12'd0,    1'b0, 32'h0,        8'd0}
        };
        // Zero lengths act as one slot; the last setting returns to the reset values.
        lead_set = '{8'd1, 8'd255, 8'd0, 8'd5, 8'd62};
        gap_set = '{16'd1, 16'd0, 16'd65535, 16'd2, 16'd2500};
        phase_items = '{500, 250, 250, 450, 250};

        servo_reset_state();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_requests[i])
            send_request(opening_requests[i].op, opening_requests[i].ch,
                         opening_requests[i].val, opening_requests[i].typed,
                         opening_requests[i].pins, opening_requests[i].rd);

        paused = 1'b0;
        held = 1'b0;
        for (int p = 0; p < PHASES; p++)
        begin
            program_windows(lead_set[p], gap_set[p]);
            start_count = accepted_count;
            while (accepted_count - start_count < phase_items[p])
            begin
                if ((accepted_count - start_count) % 80 == 0)
                    steady = ($urandom_range(0, 3) == 0);
                if (p == 0 && !held && accepted_count - start_count >= 60)
                begin
                    hold_output = 1'b1;
                    held = 1'b1;
                end
                if (p == 1 && !paused && accepted_count - start_count > 100)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
                r = $urandom_range(0, 99);
                if (r < 76)
                    send_request(msp_pkg::OP_TICK, 7'($urandom), 12'($urandom),
                                 1'b0, '0, '0);
                else if (r < 82)
                begin
                    // A complete channel set-up with random limits and angle.
                    ch = 7'($urandom_range(0, 31));
                    send_request(msp_pkg::OP_ATTACH, ch, 12'($urandom), 1'b0, '0, '0);
                    send_request(msp_pkg::OP_SETMIN, ch, 12'($urandom_range(400, 1600)),
                                 1'b0, '0, '0);
                    send_request(msp_pkg::OP_SETMAX, ch, 12'($urandom_range(1400, 2600)),
                                 1'b0, '0, '0);
                    send_request(msp_pkg::OP_WRITE, ch, 12'($urandom_range(0, 190)),
                                 1'b0, '0, '0);
                    send_request(msp_pkg::OP_READ, ch, 12'($urandom), 1'b0, '0, '0);
                end
                else
                begin
                    op = msp_pkg::op_t'($urandom_range(1, 7));
                    ch = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(0, 31))
                                                      : 7'($urandom_range(0, 127));
                    if ($urandom_range(0, 99) < 60)
                        val = (op == msp_pkg::OP_WRITE) ? 12'($urandom_range(0, 180))
                                                        : 12'($urandom_range(400, 2600));
                    else
                        val = 12'($urandom);
                    send_request(op, ch, val, 1'b0, '0, '0);
                end
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Sent %0d requests (%0d reads) over %0d window settings; %0d results checked.",
                 accepted_count, read_count, PHASES, result_count);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
